@@ hdl/byte_grid_line_scan_top_defines.svh @@
// byte_grid_line_scan_top_defines.svh: assertion macros for the line scan checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BYTE_GRID_LINE_SCAN_TOP_DEFINES_SVH
`define BYTE_GRID_LINE_SCAN_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define BGLS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgls: implication check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define BGLS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgls: next-cycle check failed");

`endif

@@ hdl/bgls_pkg.sv @@
// bgls_pkg: fixed widths, action codes, register indexes and shared structs
// for the byte grid line scan block. No dependencies.
package bgls_pkg;

    localparam int ACTION_W = 3;
    localparam int COL_W    = 6;
    localparam int ROW_W    = 7;
    localparam int DATA_W   = 8;
    localparam int POS_W    = 7;
    localparam int SHIFT_W  = 4;
    localparam int LOG2_W   = 3;
    localparam int HEIGHT_W = 7;
    localparam int CFG_W    = 7;

    localparam logic [ACTION_W-1:0] ACT_WRITE     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_READ      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_UP_CHG    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_UP_VAL    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RIGHT_CHG = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RIGHT_VAL = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_DOWN_CHG  = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_DOWN_VAL  = 3'd7;

    localparam logic REG_WIDTH_LOG2 = 1'b0;
    localparam logic REG_HEIGHT     = 1'b1;

    localparam logic [LOG2_W-1:0]   WIDTH_LOG2_RST = 3'd6;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST     = 7'd64;

    // classification of one command, front to back
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                in_range;
        logic                by_value;
        logic                dec;
    } bgls_ctl_t;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] cell_value;
    } bgls_res_t;

endpackage

@@ hdl/bgls_queue.sv @@
// bgls_queue: two-entry command queue between front and back.
// Depends on nothing; width set by parameter.
module bgls_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output logic [W-1:0] rdata
);

    localparam int DEPTH = 2;

    logic [W-1:0] entry_reg [DEPTH];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full       = (count_reg == 2'(DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign rdata      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ hdl/bgls_front.sv @@
// bgls_front: classifies an incoming transaction: range check, start address,
// scan direction, stride and end coordinate. Uses bgls_pkg.
module bgls_front #(
    parameter int  MAX_WIDTH_LOG2 = 6,
    parameter int  MAX_ROWS       = 128,
    localparam int RW             = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CW             = (RW > MAX_WIDTH_LOG2) ? RW : MAX_WIDTH_LOG2
) (
    input  logic [bgls_pkg::LOG2_W-1:0]   width_log2,
    input  logic [bgls_pkg::HEIGHT_W-1:0] height,
    input  logic [bgls_pkg::ACTION_W-1:0] action,
    input  logic [bgls_pkg::COL_W-1:0]    col,
    input  logic [bgls_pkg::ROW_W-1:0]    row,
    output bgls_pkg::bgls_ctl_t           ctl,
    output logic [RW+MAX_WIDTH_LOG2-1:0]  addr,
    output logic [CW-1:0]                 coord,
    output logic [CW-1:0]                 limit,
    output logic [RW+MAX_WIDTH_LOG2-1:0]  stride
);

    localparam int AW = RW + MAX_WIDTH_LOG2;
    localparam int EW = ((AW > bgls_pkg::ROW_W) ? AW : bgls_pkg::ROW_W) + 1;

    logic [bgls_pkg::SHIFT_W-1:0] shift;
    logic [EW-1:0] rows_eff, width_eff, col_ext, row_ext, addr_full;
    logic [EW-1:0] width_m1, rows_m1;

    always_comb
    begin
        shift = (bgls_pkg::SHIFT_W'(width_log2) > bgls_pkg::SHIFT_W'(MAX_WIDTH_LOG2)) ?
                bgls_pkg::SHIFT_W'(MAX_WIDTH_LOG2) : bgls_pkg::SHIFT_W'(width_log2);
        rows_eff  = (EW'(height) > EW'(MAX_ROWS)) ? EW'(MAX_ROWS) : EW'(height);
        width_eff = EW'(1) << shift;
        width_m1  = width_eff - EW'(1);
        rows_m1   = rows_eff - EW'(1);
        col_ext   = EW'(col);
        row_ext   = EW'(row);
        addr_full = (row_ext << shift) + col_ext;

        ctl.action   = action;
        ctl.in_range = (col_ext < width_eff) && (row_ext < rows_eff);
        ctl.by_value = action[0];
        ctl.dec      = 1'b0;
        addr         = addr_full[AW-1:0];
        coord        = row_ext[CW-1:0];
        limit        = '0;
        stride       = AW'(1);

        case (action)
            bgls_pkg::ACT_UP_CHG, bgls_pkg::ACT_UP_VAL:
            begin
                ctl.dec = 1'b1;
                stride  = width_eff[AW-1:0];
            end
            bgls_pkg::ACT_RIGHT_CHG, bgls_pkg::ACT_RIGHT_VAL:
            begin
                coord = col_ext[CW-1:0];
                limit = width_m1[CW-1:0];
            end
            bgls_pkg::ACT_DOWN_CHG, bgls_pkg::ACT_DOWN_VAL:
            begin
                stride = width_eff[AW-1:0];
                limit  = rows_m1[CW-1:0];
            end
            bgls_pkg::ACT_WRITE, bgls_pkg::ACT_READ:
            begin
                limit = '0;
            end
            default:
            begin
                limit = '0;
            end
        endcase
    end

endmodule

@@ hdl/bgls_back.sv @@
// bgls_back: grid memory and the sequencer that carries out writes, reads and
// scans one cell per cycle. Uses bgls_pkg.
module bgls_back #(
    parameter int  MAX_WIDTH_LOG2 = 6,
    parameter int  MAX_ROWS       = 128,
    localparam int RW             = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CW             = (RW > MAX_WIDTH_LOG2) ? RW : MAX_WIDTH_LOG2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  bgls_pkg::bgls_ctl_t           ctl,
    input  logic [bgls_pkg::DATA_W-1:0]   value,
    input  logic [RW+MAX_WIDTH_LOG2-1:0]  addr,
    input  logic [CW-1:0]                 coord,
    input  logic [CW-1:0]                 limit,
    input  logic [RW+MAX_WIDTH_LOG2-1:0]  stride,
    input  logic                          out_free,
    output logic                          cmd_pop,
    output logic                          res_load,
    output bgls_pkg::bgls_res_t           res
);

    localparam int AW    = RW + MAX_WIDTH_LOG2;
    localparam int DEPTH = MAX_ROWS << MAX_WIDTH_LOG2;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    logic [bgls_pkg::DATA_W-1:0] grid_mem [DEPTH];
    logic [bgls_pkg::DATA_W-1:0] rd_data_reg;

    logic [1:0]                    state_reg, state_next;
    logic [AW-1:0]                 cur_addr_reg, cur_addr_next;
    logic [CW-1:0]                 cur_coord_reg, cur_coord_next;
    logic [CW-1:0]                 limit_reg, limit_next;
    logic [AW-1:0]                 stride_reg, stride_next;
    logic                          dec_reg, dec_next;
    logic                          by_value_reg, by_value_next;
    logic [bgls_pkg::DATA_W-1:0]   seek_reg, seek_next;
    logic [bgls_pkg::ACTION_W-1:0] action_reg, action_next;

    logic          mem_we;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] step_addr;
    logic [CW-1:0] step_coord;
    logic          hit;

    always_comb
    begin
        state_next     = state_reg;
        cur_addr_next  = cur_addr_reg;
        cur_coord_next = cur_coord_reg;
        limit_next     = limit_reg;
        stride_next    = stride_reg;
        dec_next       = dec_reg;
        by_value_next  = by_value_reg;
        seek_next      = seek_reg;
        action_next    = action_reg;
        cmd_pop        = 1'b0;
        res_load       = 1'b0;
        res            = '0;
        mem_we         = 1'b0;
        rd_addr        = cur_addr_reg;
        step_addr      = dec_reg ? (cur_addr_reg - stride_reg) : (cur_addr_reg + stride_reg);
        step_coord     = dec_reg ? (cur_coord_reg - CW'(1)) : (cur_coord_reg + CW'(1));
        hit            = by_value_reg ? (rd_data_reg == seek_reg) : (rd_data_reg != seek_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    if (!ctl.in_range)
                    begin
                        res_load = 1'b1;
                    end
                    else if (ctl.action == bgls_pkg::ACT_WRITE)
                    begin
                        mem_we         = 1'b1;
                        res_load       = 1'b1;
                        res.found      = 1'b1;
                        res.cell_value = value;
                    end
                    else
                    begin
                        rd_addr        = addr;
                        cur_addr_next  = addr;
                        cur_coord_next = coord;
                        limit_next     = limit;
                        stride_next    = stride;
                        dec_next       = ctl.dec;
                        by_value_next  = ctl.by_value;
                        seek_next      = value;
                        action_next    = ctl.action;
                        state_next     = S_START;
                    end
                end
            end
            S_START:
            begin
                if (action_reg == bgls_pkg::ACT_READ)
                begin
                    res_load       = 1'b1;
                    res.found      = 1'b1;
                    res.cell_value = rd_data_reg;
                    state_next     = S_IDLE;
                end
                else
                begin
                    // change scans compare against the start cell
                    if (!by_value_reg)
                    begin
                        seek_next = rd_data_reg;
                    end
                    if (cur_coord_reg == limit_reg)
                    begin
                        res_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_addr        = step_addr;
                        cur_addr_next  = step_addr;
                        cur_coord_next = step_coord;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    res_load       = 1'b1;
                    res.found      = 1'b1;
                    res.position   = bgls_pkg::POS_W'(cur_coord_reg);
                    res.cell_value = rd_data_reg;
                    state_next     = S_IDLE;
                end
                else if (cur_coord_reg == limit_reg)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_addr        = step_addr;
                    cur_addr_next  = step_addr;
                    cur_coord_next = step_coord;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_addr_reg  <= cur_addr_next;
        cur_coord_reg <= cur_coord_next;
        limit_reg     <= limit_next;
        stride_reg    <= stride_next;
        dec_reg       <= dec_next;
        by_value_reg  <= by_value_next;
        seek_reg      <= seek_next;
        action_reg    <= action_next;
    end

    // grid store: at most one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[addr] <= value;
        end
        rd_data_reg <= grid_mem[rd_addr];
    end

endmodule

@@ hdl/byte_grid_line_scan_top.sv @@
// byte_grid_line_scan_top: top level of the byte grid line scan block.
// Instantiates bgls_front, bgls_queue and bgls_back; uses bgls_pkg.
//
// Byte grid with line scans. The grid holds MAX_ROWS << MAX_WIDTH_LOG2 bytes
// in one on-chip memory, addressed as (row << width_log2) + col, and is not
// cleared at reset: read only cells that were written. Each input transaction
// writes a cell, reads a cell, or scans up, right or down from (col,row) for
// the first cell that differs from the start cell (change scans) or that equals
// the given value (value scans); the start cell never counts as a hit. Every
// transaction yields exactly one result transaction. Out-of-range coordinates
// and scans that hit the grid edge return found 0 with zero position and data.
// Sequencer steps: a write or an out-of-range command ends in IDLE, a read in
// START; a scan passes START and, unless it starts at the edge, steps cell by
// cell in SCAN, at most height - 1 cells when vertical and width - 1 when
// right; the single read port of the grid memory, one registered read per
// cycle, sets this. Input is accepted into a two-entry command queue while the
// sequencer works and while a result waits in the output register, so the
// input side stalls only once the queue is full. Config registers (index 0
// width_log2, index 1 height) must be written only while no transaction is in
// flight; they are sampled when an input transaction is accepted.
module byte_grid_line_scan_top #(
    parameter int MAX_WIDTH_LOG2 = 6,
    parameter int MAX_ROWS       = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          wr_en,
    input  logic                          wr_index,
    input  logic [bgls_pkg::CFG_W-1:0]    wr_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bgls_pkg::ACTION_W-1:0] action,
    input  logic [bgls_pkg::COL_W-1:0]    col,
    input  logic [bgls_pkg::ROW_W-1:0]    row,
    input  logic [bgls_pkg::DATA_W-1:0]   value,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic [bgls_pkg::POS_W-1:0]    position,
    output logic [bgls_pkg::DATA_W-1:0]   cell_value
);

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW  = RW + MAX_WIDTH_LOG2;
    localparam int CW  = (RW > MAX_WIDTH_LOG2) ? RW : MAX_WIDTH_LOG2;
    localparam int QW  = $bits(bgls_pkg::bgls_ctl_t) + bgls_pkg::DATA_W + 2 * AW + 2 * CW;

    // configuration registers
    logic [bgls_pkg::LOG2_W-1:0]   width_log2_reg;
    logic [bgls_pkg::HEIGHT_W-1:0] height_reg;

    // front side classification
    bgls_pkg::bgls_ctl_t f_ctl;
    logic [AW-1:0]       f_addr, f_stride;
    logic [CW-1:0]       f_coord, f_limit;

    // queue
    logic          q_push, q_full, q_pop, q_valid;
    logic [QW-1:0] q_wdata, q_rdata;

    // back side command
    bgls_pkg::bgls_ctl_t         b_ctl;
    logic [bgls_pkg::DATA_W-1:0] b_value;
    logic [AW-1:0]               b_addr, b_stride;
    logic [CW-1:0]               b_coord, b_limit;

    // result path
    logic                out_free;
    logic                res_load;
    bgls_pkg::bgls_res_t res;
    logic                out_valid_reg, out_valid_next;
    bgls_pkg::bgls_res_t out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_log2_reg <= bgls_pkg::WIDTH_LOG2_RST;
            height_reg     <= bgls_pkg::HEIGHT_RST;
        end
        else if (wr_en)
        begin
            if (wr_index == bgls_pkg::REG_WIDTH_LOG2)
            begin
                width_log2_reg <= wr_data[bgls_pkg::LOG2_W-1:0];
            end
            if (wr_index == bgls_pkg::REG_HEIGHT)
            begin
                height_reg <= wr_data[bgls_pkg::HEIGHT_W-1:0];
            end
        end
    end

    bgls_front #(
        .MAX_WIDTH_LOG2 (MAX_WIDTH_LOG2),
        .MAX_ROWS       (MAX_ROWS)
    ) u_front (
        .width_log2 (width_log2_reg),
        .height     (height_reg),
        .action     (action),
        .col        (col),
        .row        (row),
        .ctl        (f_ctl),
        .addr       (f_addr),
        .coord      (f_coord),
        .limit      (f_limit),
        .stride     (f_stride)
    );

    // a transaction is taken whenever the queue has room
    assign in_ready = ~q_full;
    assign q_push   = in_valid & ~q_full;
    assign q_wdata  = {f_ctl, value, f_addr, f_coord, f_limit, f_stride};

    bgls_queue #(
        .W (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .wdata      (q_wdata),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .rdata      (q_rdata)
    );

    assign {b_ctl, b_value, b_addr, b_coord, b_limit, b_stride} = q_rdata;

    // sequencer starts a command only when the result slot will be free;
    // it fills the slot at most once per command
    assign out_free = ~out_valid_reg | out_ready;

    bgls_back #(
        .MAX_WIDTH_LOG2 (MAX_WIDTH_LOG2),
        .MAX_ROWS       (MAX_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .ctl       (b_ctl),
        .value     (b_value),
        .addr      (b_addr),
        .coord     (b_coord),
        .limit     (b_limit),
        .stride    (b_stride),
        .out_free  (out_free),
        .cmd_pop   (q_pop),
        .res_load  (res_load),
        .res       (res)
    );

    always_comb
    begin
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = out_res_reg.found;
    assign position   = out_res_reg.position;
    assign cell_value = out_res_reg.cell_value;

endmodule

@@ hdl/bgls_checker.sv @@
// bgls_checker: port-level checks for byte_grid_line_scan_top, bound in below.
// Uses the assertion macros of byte_grid_line_scan_top_defines.svh.
`include "byte_grid_line_scan_top_defines.svh"

module bgls_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          found,
    input logic [bgls_pkg::POS_W-1:0]    position,
    input logic [bgls_pkg::DATA_W-1:0]   cell_value
);

    // transactions accepted but not yet delivered
    logic [2:0] pend_reg, pend_next;

    assign pend_next = pend_reg + 3'(in_valid & in_ready) - 3'(out_valid & out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `BGLS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found) && $stable(position) && $stable(cell_value))
    `BGLS_ASSERT_IMP(a_miss_zero, out_valid && !found, position == 7'd0 && cell_value == 8'd0)
    `BGLS_ASSERT_IMP(a_no_orphan, out_valid, pend_reg != 3'd0)
    `BGLS_ASSERT_IMP(a_capacity, 1'b1, pend_reg <= 3'd4)

endmodule

bind byte_grid_line_scan_top bgls_checker u_bgls_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .position   (position),
    .cell_value (cell_value)
);

@@ dv/testbench.sv @@
// testbench.sv: self-checking testbench for byte_grid_line_scan_top.
// Needs bgls_pkg and the byte_grid_line_scan_top RTL; holds its own grid predictor.
`timescale 1ns / 100ps

// Outline
//   - The low FILL_CELLS grid addresses are written once (64 x 8). The grid memory
//     has no reset, so every grid shape used keeps height << width_log2 within
//     that region, and no read or scan touches a cell that was never written.
//   - Directed cases cover grid corners, scans that start on an edge, a start cell
//     that equals the sought value, out-of-range and zero-height accesses, and an
//     oversized width_log2.
//   - Random traffic runs under three idle mixes, over a plan of grid shapes.
// Each accepted command transaction is run through the local grid predictor.
// Each result transaction is compared field by field with the oldest prediction.
module testbench;

    localparam int WIDTH_LOG2_CAP    = 6;                       // DUT MAX_WIDTH_LOG2
    localparam int GRID_ROWS         = 128;                     // DUT MAX_ROWS
    localparam int GRID_CELLS        = GRID_ROWS << WIDTH_LOG2_CAP;
    localparam int FILL_ROWS         = 8;                       // rows written at full width
    localparam int FILL_CELLS        = FILL_ROWS << WIDTH_LOG2_CAP;
    localparam int HEIGHT_MAX        = 127;
    localparam int SEGMENT_ITEMS     = 14;
    localparam int PLAN_SEGMENTS     = 10;
    localparam int DRAIN_CYCLES      = 140;                     // > longest scan
    localparam int WATCHDOG_LIMIT    = 2000;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          wr_en;
    logic                          wr_index;
    logic [bgls_pkg::CFG_W-1:0]    wr_data;
    logic                          in_valid;
    logic                          in_ready;
    logic [bgls_pkg::ACTION_W-1:0] cmd_action;
    logic [bgls_pkg::COL_W-1:0]    cmd_col;
    logic [bgls_pkg::ROW_W-1:0]    cmd_row;
    logic [bgls_pkg::DATA_W-1:0]   cmd_value;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          res_found;
    logic [bgls_pkg::POS_W-1:0]    res_position;
    logic [bgls_pkg::DATA_W-1:0]   res_cell_value;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;

    // grid shapes for the random segments, each within the filled region;
    // the last segment of a phase is random
    int plan_log2   [0:PLAN_SEGMENTS-2] = '{6, 0, 7, 3, 6, 0, 2, 5, 1};
    int plan_height [0:PLAN_SEGMENTS-2] = '{8, 1, 8, 64, 1, 127, 0, 16, 127};

    // local copy of the register settings and the grid contents
    logic [bgls_pkg::LOG2_W-1:0]   cfg_log2   = bgls_pkg::WIDTH_LOG2_RST;
    logic [bgls_pkg::HEIGHT_W-1:0] cfg_height = bgls_pkg::HEIGHT_RST;
    logic [bgls_pkg::DATA_W-1:0]   grid_mem [0:GRID_CELLS-1];

    // predicted result transactions, oldest first
    bgls_pkg::bgls_res_t scan_results_due [$];

    byte_grid_line_scan_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (cmd_action),
        .col        (cmd_col),
        .row        (cmd_row),
        .value      (cmd_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (res_found),
        .position   (res_position),
        .cell_value (res_cell_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicts one command and applies its write to the grid copy.
    // Registers are sampled as the command is accepted, as the DUT does.
    function automatic bgls_pkg::bgls_res_t grid_cmd_result(
        logic [bgls_pkg::ACTION_W-1:0] act,
        logic [bgls_pkg::COL_W-1:0]    c,
        logic [bgls_pkg::ROW_W-1:0]    r,
        logic [bgls_pkg::DATA_W-1:0]   v);
        bgls_pkg::bgls_res_t         res;
        int                          shift;
        int                          width;
        int                          rows;
        int                          addr;
        int                          x;
        int                          y;
        int                          dx;
        int                          dy;
        logic                        walking;
        logic                        by_value;
        logic [bgls_pkg::DATA_W-1:0] start_byte;
        logic [bgls_pkg::DATA_W-1:0] cur;

        res = '0;
        shift = (cfg_log2 > WIDTH_LOG2_CAP) ? WIDTH_LOG2_CAP : cfg_log2;
        width = 1 << shift;
        rows = (cfg_height > GRID_ROWS) ? GRID_ROWS : cfg_height;
        if (c >= width || r >= rows)
            return res;

        addr = (int'(r) << shift) + c;
        start_byte = grid_mem[addr];
        by_value = (act == bgls_pkg::ACT_UP_VAL) || (act == bgls_pkg::ACT_RIGHT_VAL) ||
                   (act == bgls_pkg::ACT_DOWN_VAL);
        x = c;
        y = r;
        dx = 0;
        dy = 0;
        case (act)
            bgls_pkg::ACT_WRITE:
            begin
                grid_mem[addr] = v;
                res.found = 1'b1;
                res.cell_value = v;
            end
            bgls_pkg::ACT_READ:
            begin
                res.found = 1'b1;
                res.cell_value = start_byte;
            end
            bgls_pkg::ACT_UP_CHG, bgls_pkg::ACT_UP_VAL:       dy = -1;
            bgls_pkg::ACT_RIGHT_CHG, bgls_pkg::ACT_RIGHT_VAL: dx = 1;
            default:                                          dy = 1;
        endcase

        // step away from the start cell; the start cell itself never hits
        walking = (dx != 0) || (dy != 0);
        while (walking)
        begin
            x += dx;
            y += dy;
            if (y < 0 || y >= rows || x >= width)
                walking = 1'b0;
            else
            begin
                cur = grid_mem[(y << shift) + x];
                if (by_value ? (cur == v) : (cur != start_byte))
                begin
                    res.found = 1'b1;
                    res.position = bgls_pkg::POS_W'((dx != 0) ? x : y);
                    res.cell_value = cur;
                    walking = 1'b0;
                end
            end
        end
        return res;
    endfunction

    // Tile bytes: a few recurring values so value scans find something.
    function automatic logic [bgls_pkg::DATA_W-1:0] tile_byte();
        case ($urandom_range(4))
            0:       return 8'h11;
            1:       return 8'h80;
            2:       return 8'hFF;
            3:       return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // One command transaction. Valid stays high from item to item unless the
    // sender idles; payload is held until the handshake.
    task automatic send_cmd(logic [bgls_pkg::ACTION_W-1:0] act,
                            logic [bgls_pkg::COL_W-1:0] c,
                            logic [bgls_pkg::ROW_W-1:0] r,
                            logic [bgls_pkg::DATA_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        cmd_action <= act;
        cmd_col    <= c;
        cmd_row    <= r;
        cmd_value  <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        scan_results_due.push_back(grid_cmd_result(act, c, r, v));
    endtask

    // Drop valid and hold off until every predicted result has arrived.
    task automatic wait_results_done();
        @(negedge clk);
        in_valid <= 1'b0;
        while (scan_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [bgls_pkg::CFG_W-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
        wr_en <= 1'b0;
        if (idx == bgls_pkg::REG_WIDTH_LOG2)
            cfg_log2 = data[bgls_pkg::LOG2_W-1:0];
        else
            cfg_height = data[bgls_pkg::HEIGHT_W-1:0];
    endtask

    // Registers change only with nothing in flight. Unused upper bits of the
    // width_log2 write carry random junk.
    task automatic set_grid_shape(int log2, int rows);
        logic [bgls_pkg::CFG_W-1:0] data;

        wait_results_done();
        data = bgls_pkg::CFG_W'($urandom);
        data[bgls_pkg::LOG2_W-1:0] = bgls_pkg::LOG2_W'(log2);
        write_reg(bgls_pkg::REG_WIDTH_LOG2, data);
        write_reg(bgls_pkg::REG_HEIGHT, bgls_pkg::CFG_W'(rows));
    endtask

    task automatic send_random_cmd();
        int                            shift;
        int                            ew;
        int                            eh;
        logic [bgls_pkg::ACTION_W-1:0] act;
        logic [bgls_pkg::COL_W-1:0]    c;
        logic [bgls_pkg::ROW_W-1:0]    r;
        logic [bgls_pkg::DATA_W-1:0]   v;

        shift = (cfg_log2 > WIDTH_LOG2_CAP) ? WIDTH_LOG2_CAP : cfg_log2;
        ew = 1 << shift;
        eh = cfg_height;
        act = bgls_pkg::ACTION_W'($urandom_range(7));
        // mostly in range, now and then anywhere the field allows
        c = ($urandom_range(9) == 0) ? bgls_pkg::COL_W'($urandom_range(63))
                                     : bgls_pkg::COL_W'($urandom_range(ew - 1));
        r = ($urandom_range(9) == 0 || eh == 0) ? bgls_pkg::ROW_W'($urandom_range(127))
                                                : bgls_pkg::ROW_W'($urandom_range(eh - 1));
        v = ($urandom_range(3) == 0) ? bgls_pkg::DATA_W'($urandom) : tile_byte();
        send_cmd(act, c, r, v);
    endtask

    // The filled region gets written: a zero background with sparse tiles,
    // so change scans run long and value scans sometimes reach the edge.
    task automatic test_grid_fill();
        set_grid_shape(WIDTH_LOG2_CAP, FILL_ROWS);
        for (int r = 0; r < FILL_ROWS; r++)
            for (int c = 0; c < (1 << WIDTH_LOG2_CAP); c++)
                send_cmd(bgls_pkg::ACT_WRITE, bgls_pkg::COL_W'(c), bgls_pkg::ROW_W'(r),
                         ($urandom_range(15) == 0) ? tile_byte() : 8'h00);
        wait_results_done();
    endtask

    task automatic test_directed_edges();
        // corners, value extremes
        send_cmd(bgls_pkg::ACT_WRITE, 6'd0, 7'd0, 8'hFF);
        send_cmd(bgls_pkg::ACT_READ, 6'd0, 7'd0, 8'h00);
        send_cmd(bgls_pkg::ACT_WRITE, 6'd63, 7'd7, 8'h00);
        send_cmd(bgls_pkg::ACT_READ, 6'd63, 7'd7, 8'hFF);
        // scans that start on the edge they move toward
        send_cmd(bgls_pkg::ACT_UP_CHG, 6'd10, 7'd0, 8'h00);
        send_cmd(bgls_pkg::ACT_DOWN_VAL, 6'd20, 7'd7, 8'h11);
        send_cmd(bgls_pkg::ACT_RIGHT_CHG, 6'd63, 7'd4, 8'h00);
        // start cell equal to the sought value is skipped
        send_cmd(bgls_pkg::ACT_WRITE, 6'd5, 7'd2, 8'h3C);
        send_cmd(bgls_pkg::ACT_WRITE, 6'd5, 7'd3, 8'h3C);
        send_cmd(bgls_pkg::ACT_DOWN_VAL, 6'd5, 7'd2, 8'h3C);
        send_cmd(bgls_pkg::ACT_UP_VAL, 6'd5, 7'd3, 8'h3C);
        send_cmd(bgls_pkg::ACT_UP_CHG, 6'd5, 7'd3, 8'h00);
        // scans across the whole line, most likely to the edge
        send_cmd(bgls_pkg::ACT_DOWN_VAL, 6'd1, 7'd0, 8'h5B);
        send_cmd(bgls_pkg::ACT_RIGHT_VAL, 6'd0, 7'd1, 8'hA5);
        // row beyond height: no write, no scan
        send_cmd(bgls_pkg::ACT_WRITE, 6'd3, 7'd8, 8'h99);
        send_cmd(bgls_pkg::ACT_DOWN_CHG, 6'd3, 7'd8, 8'h00);
        // short grid: out-of-range write must leave the cell alone
        set_grid_shape(WIDTH_LOG2_CAP, 4);
        send_cmd(bgls_pkg::ACT_WRITE, 6'd7, 7'd6, 8'h77);
        send_cmd(bgls_pkg::ACT_DOWN_CHG, 6'd7, 7'd2, 8'h00);
        // zero height: everything out of range
        set_grid_shape(WIDTH_LOG2_CAP, 0);
        send_cmd(bgls_pkg::ACT_WRITE, 6'd0, 7'd0, 8'h42);
        // width_log2 above the cap acts as the cap
        set_grid_shape(7, FILL_ROWS);
        send_cmd(bgls_pkg::ACT_READ, 6'd7, 7'd5, 8'h00);
        send_cmd(bgls_pkg::ACT_READ, 6'd0, 7'd0, 8'h00);
        // one-column grid
        set_grid_shape(0, HEIGHT_MAX);
        send_cmd(bgls_pkg::ACT_READ, 6'd1, 7'd0, 8'h00);
        send_cmd(bgls_pkg::ACT_RIGHT_CHG, 6'd0, 7'd5, 8'h00);
        send_cmd(bgls_pkg::ACT_UP_VAL, 6'd0, 7'd126, 8'h11);
        // tall narrow grid: longest vertical scans
        set_grid_shape(2, HEIGHT_MAX);
        send_cmd(bgls_pkg::ACT_DOWN_VAL, 6'd1, 7'd0, 8'h5B);
        send_cmd(bgls_pkg::ACT_UP_CHG, 6'd3, 7'd126, 8'h00);
    endtask

    task automatic test_random_traffic(int s_pct, int r_pct);
        int lg;
        int sh;
        int hmax;

        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int seg = 0; seg < PLAN_SEGMENTS; seg++)
        begin
            if (seg < PLAN_SEGMENTS - 1)
                set_grid_shape(plan_log2[seg], plan_height[seg]);
            else
            begin
                // random shape, still inside the filled region
                lg = $urandom_range(7);
                sh = (lg > WIDTH_LOG2_CAP) ? WIDTH_LOG2_CAP : lg;
                hmax = FILL_CELLS >> sh;
                if (hmax > HEIGHT_MAX)
                    hmax = HEIGHT_MAX;
                set_grid_shape(lg, $urandom_range(hmax));
            end
            for (int i = 0; i < SEGMENT_ITEMS; i++)
                send_random_cmd();
        end
    endtask

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Result check against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        bgls_pkg::bgls_res_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (scan_results_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, actual %0d/%0d/%h",
                         $time, res_found, res_position, res_cell_value);
            end
            else
            begin
                want = scan_results_due.pop_front();
                if (res_found !== want.found)
                begin
                    mismatch_count++;
                    $display("%0t: found mismatch: expected %0d, actual %0d",
                             $time, want.found, res_found);
                end
                if (res_position !== want.position)
                begin
                    mismatch_count++;
                    $display("%0t: position mismatch: expected %0d, actual %0d",
                             $time, want.position, res_position);
                end
                if (res_cell_value !== want.cell_value)
                begin
                    mismatch_count++;
                    $display("%0t: cell_value mismatch: expected %h, actual %h",
                             $time, want.cell_value, res_cell_value);
                end
            end
        end
    end

    // Watchdog: cycles in a row with no transaction and no register write.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        wr_en      = 1'b0;
        wr_index   = bgls_pkg::REG_WIDTH_LOG2;
        wr_data    = '0;
        in_valid   = 1'b0;
        cmd_action = bgls_pkg::ACT_WRITE;
        cmd_col    = '0;
        cmd_row    = '0;
        cmd_value  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 51;
        test_grid_fill();
        test_directed_edges();
        test_random_traffic(29, 51);
        test_random_traffic(51, 29);
        test_random_traffic(0, 0);

        // let any stray result show up before the verdict
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && scan_results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
